@@ hw/rtl/bcc_pkg.sv @@
package bcc_pkg;

   // click codes reported per poll
   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   // configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_DEBOUNCE_TIME       = 2'd0;
   localparam csr_index_type CSR_LONG_PRESS_TIME     = 2'd1;
   localparam csr_index_type CSR_DOUBLE_CLICK_WINDOW = 2'd2;

   localparam logic [15:0] DEBOUNCE_TIME_RST       = 16'd50;
   localparam logic [15:0] LONG_PRESS_TIME_RST     = 16'd3000;
   localparam logic [15:0] DOUBLE_CLICK_WINDOW_RST = 16'd400;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned REQ_W  = 40;
   localparam int unsigned RSP_W  = 8;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [15:0] double_click_window;
   } btn_cfg_type;

   typedef struct packed {
      logic              last_raw;
      logic              stable;
      logic [TIME_W-1:0] raw_change_time;
      logic [TIME_W-1:0] press_start_time;
      logic              long_reported;
      logic              click_pending;
      logic [TIME_W-1:0] first_click_time;
   } btn_state_type;

endpackage

@@ hw/rtl/button_click_classifier_core.sv @@
// channel | dir | tdata fields, lowest bit first           | tuser
// req_    | in  | now_ms[31:0], raw_pressed[32], zero pad   | -
// rsp_    | out | click_event[1:0], debounced_pressed[2], pad| -
// csr_    | in  | csr_index = register, csr_data = value    | -
//
// one item per cycle sustained while the result side does not stall: each
// poll waits in the input register, then the debounce/classify logic updates
// the button state and loads the result register, from which its result is
// offered
// reset (synchronous) clears the button state and loads default settings
// a stalled result register holds the input register; csr_ready is always high
module button_click_classifier_core (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ms[31:0], raw_pressed[32], zeros[39:33]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // click_event[1:0], debounced_pressed[2], zeros[7:3]
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  bcc_pkg::csr_index_type csr_index,
   input  logic [15:0] csr_data
);
   import bcc_pkg::*;

   // settings
   btn_cfg_type   cfg_ff;
   btn_cfg_type   cfg_in;

   // debounce and click state
   btn_state_type state_ff;
   btn_state_type state_in;

   // input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [TIME_W-1:0] in_now_ff;
   logic              in_raw_ff;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   event_type         rsp_event_ff;
   logic              rsp_level_ff;

   event_type         step_event;
   logic              advance;

   // poll leaves the input register when the result register frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // register writes, out-of-range index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_TIME:       cfg_in.debounce_time       = csr_data;
            CSR_LONG_PRESS_TIME:     cfg_in.long_press_time     = csr_data;
            CSR_DOUBLE_CLICK_WINDOW: cfg_in.double_click_window = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   bcc_step u_step (
      .cfg         (cfg_ff),
      .state_cur   (state_ff),
      .now_ms      (in_now_ff),
      .raw_pressed (in_raw_ff),
      .state_nxt   (state_in),
      .click_event (step_event)
   );

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time       <= DEBOUNCE_TIME_RST;
         cfg_ff.long_press_time     <= LONG_PRESS_TIME_RST;
         cfg_ff.double_click_window <= DOUBLE_CLICK_WINDOW_RST;
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_now_ff <= req_tdata[31:0];
         in_raw_ff <= req_tdata[32];
      end
      if (advance) begin
         rsp_event_ff <= step_event;
         rsp_level_ff <= state_in.stable;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_level_ff, rsp_event_ff};

endmodule

@@ hw/rtl/bcc_step.sv @@
module bcc_step (
   input  bcc_pkg::btn_cfg_type   cfg,
   input  bcc_pkg::btn_state_type state_cur,
   input  logic [31:0]            now_ms,
   input  logic                   raw_pressed,
   output bcc_pkg::btn_state_type state_nxt,
   output bcc_pkg::event_type     click_event
);
   import bcc_pkg::*;

   logic [TIME_W-1:0] raw_change_time;
   logic [TIME_W-1:0] since_change;
   logic [TIME_W-1:0] since_press;
   logic [TIME_W-1:0] since_first;
   logic              accept_level;
   logic              new_press;
   logic              long_hit;
   logic              single_hit;
   btn_state_type     s;

   always_comb begin
      s = state_cur;
      click_event = EV_NONE;

      // raw edge restarts the debounce timer
      raw_change_time = (raw_pressed != state_cur.last_raw) ? now_ms
                                                            : state_cur.raw_change_time;
      s.last_raw        = raw_pressed;
      s.raw_change_time = raw_change_time;

      since_change = now_ms - raw_change_time;
      accept_level = (since_change >= {16'd0, cfg.debounce_time})
                     && (state_cur.stable != raw_pressed);
      new_press    = accept_level && raw_pressed;

      if (accept_level) begin
         s.stable = raw_pressed;
      end
      if (new_press) begin
         s.press_start_time = now_ms;
         s.long_reported    = 1'b0;
         if (!state_cur.click_pending) begin
            s.click_pending    = 1'b1;
            s.first_click_time = now_ms;
         end else begin
            s.click_pending = 1'b0;
            click_event     = EV_DOUBLE;
         end
      end

      since_press = now_ms - s.press_start_time;
      long_hit    = s.stable && !s.long_reported
                    && (since_press >= {16'd0, cfg.long_press_time});
      if (long_hit) begin
         s.long_reported = 1'b1;
         s.click_pending = 1'b0;
         click_event     = EV_LONG;
      end

      since_first = now_ms - s.first_click_time;
      single_hit  = s.click_pending && !s.stable
                    && (since_first > {16'd0, cfg.double_click_window});
      if (single_hit) begin
         s.click_pending = 1'b0;
         click_event     = EV_SINGLE;
      end

      state_nxt = s;
   end

endmodule

@@ hw/rtl/bcc_checker.sv @@
module bcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   import bcc_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // long press and double click only while the button is held
   a_press_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == EV_LONG || rsp_tdata[1:0] == EV_DOUBLE)
      |-> rsp_tdata[2])
      else $error("press event with button released");

   // single click only once released
   a_single_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == EV_SINGLE |-> !rsp_tdata[2])
      else $error("single click with button held");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:3] == 5'd0)
      else $error("result padding not zero");

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/tb_button_click_classifier_core.sv @@
`timescale 1ns / 100ps

module tb_button_click_classifier_core;
   import bcc_pkg::*;

   // register index that maps to no register, writes to it are dropped
   localparam csr_index_type CSR_NO_REG = 2'd3;
   // cycles without any handshake before the run is declared hung
   localparam int unsigned QUIET_LIMIT = 4000;
   // a result passes the input and result registers after its poll, leave some margin
   localparam int unsigned SETTLE_CYCLES = 6;

   // what one poll should produce
   typedef struct packed {
      event_type click;
      logic      level;
   } click_result_type;

   // tracks the button state and the settings, holds the results still owed
   class click_scoreboard;
      logic [15:0]      settle_ms;
      logic [15:0]      long_ms;
      logic [15:0]      window_ms;
      bit               last_raw;
      bit               stable;
      bit               long_done;
      bit               pending;
      bit [31:0]        change_at;
      bit [31:0]        press_at;
      bit [31:0]        first_at;
      click_result_type expected_clicks[$];
      int unsigned      errors;

      function new();
         settle_ms   = DEBOUNCE_TIME_RST;
         long_ms     = LONG_PRESS_TIME_RST;
         window_ms   = DOUBLE_CLICK_WINDOW_RST;
         last_raw    = 1'b0;
         stable      = 1'b0;
         long_done   = 1'b0;
         pending     = 1'b0;
         change_at   = '0;
         press_at    = '0;
         first_at    = '0;
         errors      = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_DEBOUNCE_TIME:       settle_ms = value;
            CSR_LONG_PRESS_TIME:     long_ms = value;
            CSR_DOUBLE_CLICK_WINDOW: window_ms = value;
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return expected_clicks.size();
      endfunction

      // advance the button state by one accepted poll
      function void note_poll(bit [31:0] now, bit raw);
         click_result_type res;
         bit [31:0]        held;
         res.click = EV_NONE;
         if (raw != last_raw) begin
            last_raw  = raw;
            change_at = now;
         end
         held = now - change_at;
         if (held >= 32'(settle_ms) && stable != last_raw) begin
            stable = last_raw;
            if (stable) begin
               press_at  = now;
               long_done = 1'b0;
               if (!pending) begin
                  pending  = 1'b1;
                  first_at = now;
               end else begin
                  pending   = 1'b0;
                  res.click = EV_DOUBLE;
               end
            end
         end
         held = now - press_at;
         if (stable && !long_done && held >= 32'(long_ms)) begin
            long_done = 1'b1;
            pending   = 1'b0;
            res.click = EV_LONG;
         end
         held = now - first_at;
         if (pending && !stable && held > 32'(window_ms)) begin
            pending   = 1'b0;
            res.click = EV_SINGLE;
         end
         res.level = stable;
         expected_clicks.push_back(res);
      endfunction

      function void check_result(logic [7:0] data);
         click_result_type want;
         if (expected_clicks.size() == 0) begin
            errors++;
            $display("%0t: result with no poll outstanding, click_event %0d level %0b",
                     $time, data[1:0], data[2]);
            return;
         end
         want = expected_clicks.pop_front();
         if (data[1:0] !== want.click) begin
            errors++;
            $display("%0t: click_event expected %0d got %0d", $time, want.click, data[1:0]);
         end
         if (data[2] !== want.level) begin
            errors++;
            $display("%0t: debounced_pressed expected %0b got %0b",
                     $time, want.level, data[2]);
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [39:0]   req_tdata;   // now_ms[31:0], raw_pressed[32], zeros[39:33]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [7:0]    rsp_tdata;   // click_event[1:0], debounced_pressed[2], zeros[7:3]
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [15:0]   csr_data;

   click_scoreboard sb;

   // stimulus side view of the settings and the time cursor
   int unsigned cur_db;
   int unsigned cur_lp;
   int unsigned cur_win;
   bit [31:0]   t_ms;
   bit          calm;          // no new idling starts on either side while set
   int unsigned polls_sent;
   int unsigned stall_left;
   int unsigned quiet_cycles;

   button_click_classifier_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // idle length before an item: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // a value at or around a threshold, or anywhere up to twice it plus two
   function automatic bit [31:0] near(int unsigned x);
      case ($urandom_range(0, 4))
         0: return (x == 0) ? 0 : x - 1;
         1: return x;
         2: return x + 1;
         default: return $urandom_range(0, 2 * x + 2);
      endcase
   endfunction

   // send one poll, valid stays up afterwards unless the next call idles
   task automatic send_poll(bit [31:0] now, bit raw);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, raw, now};
      do @(posedge clock); while (!req_tready);
      sb.note_poll(now, raw);
      polls_sent++;
      @(negedge clock);
   endtask

   // leaves csr_valid up, the caller lowers it after the last write
   task automatic csr_put(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, value);
      @(negedge clock);
   endtask

   // stop sending and let every owed result come out
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(int unsigned db, int unsigned lp, int unsigned win);
      drain();
      csr_put(CSR_DEBOUNCE_TIME, db[15:0]);
      csr_put(CSR_LONG_PRESS_TIME, lp[15:0]);
      csr_put(CSR_DOUBLE_CLICK_WINDOW, win[15:0]);
      csr_valid <= 1'b0;
      cur_db  = db;
      cur_lp  = lp;
      cur_win = win;
   endtask

   // contact bounce, then the level held until the debounce time is met
   task automatic edge_to(bit level);
      int unsigned n;
      bit [31:0]   settle_at;
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         t_ms += $urandom_range(0, cur_db / 2);
         send_poll(t_ms, (i % 2 == 0) ? level : !level);
      end
      t_ms += $urandom_range(0, cur_db / 2 + 1);
      send_poll(t_ms, level);
      settle_at = t_ms;
      // one ms short of the debounce time
      if (cur_db > 0 && $urandom_range(0, 2) == 0) begin
         t_ms = settle_at + cur_db - 1;
         send_poll(t_ms, level);
      end
      t_ms = settle_at + cur_db + $urandom_range(0, 2);
      send_poll(t_ms, level);
   endtask

   // keep the level for dur ms, polled one to three times
   task automatic hold_for(bit level, bit [31:0] dur);
      int unsigned k;
      bit [31:0]   start;
      bit [31:0]   step;
      k     = $urandom_range(1, 3);
      start = t_ms;
      step  = dur / k;
      for (int i = 1; i < k; i++) begin
         t_ms = start + step * i;
         send_poll(t_ms, level);
      end
      t_ms = start + dur;
      send_poll(t_ms, level);
   endtask

   task automatic single_click();
      bit [31:0] press_at;
      bit [31:0] expire_at;
      edge_to(1'b1);
      press_at = t_ms;
      hold_for(1'b1, $urandom_range(0, cur_lp / 2));
      edge_to(1'b0);
      expire_at = press_at + cur_win;
      // land on the last ms of the window and the first one past it
      if (expire_at - t_ms < 32'h8000_0000) begin
         t_ms = expire_at;
         send_poll(t_ms, 1'b0);
         t_ms = expire_at + 1;
         send_poll(t_ms, 1'b0);
      end
      hold_for(1'b0, $urandom_range(0, cur_win + 4));
   endtask

   task automatic double_click();
      edge_to(1'b1);
      hold_for(1'b1, $urandom_range(0, cur_win / 4));
      edge_to(1'b0);
      hold_for(1'b0, $urandom_range(0, cur_win / 4));
      edge_to(1'b1);
      hold_for(1'b1, $urandom_range(0, cur_lp / 2));
      edge_to(1'b0);
      hold_for(1'b0, near(cur_win));
   endtask

   task automatic long_press();
      edge_to(1'b1);
      hold_for(1'b1, near(cur_lp));
      if ($urandom_range(0, 1) == 0) hold_for(1'b1, $urandom_range(0, cur_lp + 2));
      edge_to(1'b0);
      hold_for(1'b0, near(cur_win));
   endtask

   // random levels with random steps, now and then a jump anywhere in time
   task automatic noise();
      int unsigned k;
      k = $urandom_range(1, 6);
      repeat (k) begin
         if ($urandom_range(0, 3) == 0) t_ms = $urandom();
         else t_ms += $urandom_range(0, 2 * cur_db + 2);
         send_poll(t_ms, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(int unsigned budget);
      int unsigned target;
      target = polls_sent + budget;
      // sometimes start close to the 32-bit wrap of the ms counter
      if ($urandom_range(0, 2) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      else t_ms = $urandom();
      while (polls_sent < target) begin
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: single_click();
            3, 4, 5: double_click();
            6, 7:    long_press();
            default: noise();
         endcase
      end
   endtask

   // result side: random back pressure with calm stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // every accepted result is checked against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // hang detection: any handshake resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_button_click_classifier_core: FAIL");
            $finish;
         end
      end
   end

   initial begin
      sb           = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_DEBOUNCE_TIME;
      csr_data     = '0;
      calm         = 1'b0;
      polls_sent   = 0;
      stall_left   = 0;
      quiet_cycles = 0;
      cur_db       = 32'(DEBOUNCE_TIME_RST);
      cur_lp       = 32'(LONG_PRESS_TIME_RST);
      cur_win      = 32'(DOUBLE_CLICK_WINDOW_RST);
      t_ms         = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed, default settings: bounce, single, double, long, wrap
      send_poll(32'd0, 1'b0);
      send_poll(32'd10, 1'b1);
      send_poll(32'd20, 1'b0);
      send_poll(32'd30, 1'b1);
      send_poll(32'd80, 1'b1);          // debounced press, window opens
      send_poll(32'd200, 1'b0);
      send_poll(32'd250, 1'b0);         // debounced release
      send_poll(32'd480, 1'b0);         // window exactly used up
      send_poll(32'd481, 1'b0);         // single click
      send_poll(32'd1000, 1'b1);
      send_poll(32'd1050, 1'b1);
      send_poll(32'd1100, 1'b0);
      send_poll(32'd1150, 1'b0);
      send_poll(32'd1200, 1'b1);
      send_poll(32'd1250, 1'b1);        // double click
      send_poll(32'd4249, 1'b1);        // one ms short of a long press
      send_poll(32'd4250, 1'b1);        // long press
      send_poll(32'd4400, 1'b0);
      send_poll(32'd4450, 1'b0);
      send_poll(32'hFFFF_FFF0, 1'b1);
      send_poll(32'h0000_0022, 1'b1);   // debounce across the counter wrap
      send_poll(32'hFFFF_FFFF, 1'b0);
      send_poll(32'h0000_0040, 1'b0);

      run_phase(70);
      // low settings: no debounce, shortest nonzero long press, no window
      apply_settings(0, 1, 0);
      run_phase(70);
      // highest settings
      apply_settings(65535, 65535, 65535);
      run_phase(70);
      // a write to the unused index must change nothing
      drain();
      csr_put(CSR_NO_REG, 16'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
      run_phase(20);
      // zero long press time: long press on the press poll itself
      apply_settings($urandom_range(0, 100), 0, $urandom_range(0, 500));
      run_phase(50);
      apply_settings($urandom_range(1, 100), $urandom_range(200, 4000),
                     $urandom_range(100, 800));
      run_phase(70);
      apply_settings($urandom_range(0, 65535), $urandom_range(1, 65535),
                     $urandom_range(0, 65535));
      run_phase(70);
      apply_settings($urandom_range(0, 20), $urandom_range(1, 300), $urandom_range(0, 300));
      run_phase(70);

      drain();
      if (sb.errors == 0) begin
         $display("tb_button_click_classifier_core: PASS");
      end else begin
         $display("tb_button_click_classifier_core: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_step.sv
hw/rtl/button_click_classifier_core.sv
hw/rtl/bcc_checker.sv
tb/sv/tb_button_click_classifier_core.sv
